/* design/sst_pkg.sv */
package sst_pkg;

   localparam int NAME_BUFFER_LEN = 16;
   localparam int OFFSET_BITS     = 24;
   localparam int LINE_BITS       = 16;
   localparam int COLUMN_BITS     = 16;
   localparam int NAME_IDX_BITS   = $clog2(NAME_BUFFER_LEN);
   localparam int KW_COUNT        = 39;
   localparam int KW_MAX_LEN      = 14;

   typedef logic [LINE_BITS-1:0]   line_type;
   typedef logic [COLUMN_BITS-1:0] col_type;
   typedef logic [OFFSET_BITS-1:0] off_type;

   // token kinds
   localparam logic [6:0] K_END          = 7'd0;
   localparam logic [6:0] K_NUMBER       = 7'd1;
   localparam logic [6:0] K_STRING       = 7'd2;
   localparam logic [6:0] K_IDENT        = 7'd3;
   localparam logic [6:0] K_ERROR        = 7'd4;
   localparam logic [6:0] K_INCLUDE      = 7'd5;
   localparam logic [6:0] K_INVOLVE      = 7'd6;
   localparam logic [6:0] K_KW0          = 7'd7;
   localparam logic [6:0] K_ADD          = 7'd7;
   localparam logic [6:0] K_SUB          = 7'd8;
   localparam logic [6:0] K_MUL          = 7'd9;
   localparam logic [6:0] K_DIV          = 7'd10;
   localparam logic [6:0] K_MOD          = 7'd11;
   localparam logic [6:0] K_EQ           = 7'd46;
   localparam logic [6:0] K_ARROW        = 7'd47;
   localparam logic [6:0] K_ASSIGN       = 7'd48;
   localparam logic [6:0] K_PLUS_ASSIGN  = 7'd49;
   localparam logic [6:0] K_INC          = 7'd50;
   localparam logic [6:0] K_MINUS_ASSIGN = 7'd51;
   localparam logic [6:0] K_DEC          = 7'd52;
   localparam logic [6:0] K_MUL_ASSIGN   = 7'd53;
   localparam logic [6:0] K_DIV_ASSIGN   = 7'd54;
   localparam logic [6:0] K_MOD_ASSIGN   = 7'd55;
   localparam logic [6:0] K_NEQ          = 7'd56;
   localparam logic [6:0] K_NOT          = 7'd57;
   localparam logic [6:0] K_LTE          = 7'd58;
   localparam logic [6:0] K_LT           = 7'd59;
   localparam logic [6:0] K_GTE          = 7'd60;
   localparam logic [6:0] K_GT           = 7'd61;
   localparam logic [6:0] K_AND          = 7'd62;
   localparam logic [6:0] K_INSERT       = 7'd63;
   localparam logic [6:0] K_OR           = 7'd64;
   localparam logic [6:0] K_LPAREN       = 7'd65;
   localparam logic [6:0] K_RPAREN       = 7'd66;
   localparam logic [6:0] K_LBRACE       = 7'd67;
   localparam logic [6:0] K_RBRACE       = 7'd68;
   localparam logic [6:0] K_LBRACK       = 7'd69;
   localparam logic [6:0] K_RBRACK       = 7'd70;
   localparam logic [6:0] K_COMMA        = 7'd71;
   localparam logic [6:0] K_DOT          = 7'd72;
   localparam logic [6:0] K_SEMI         = 7'd73;
   localparam logic [6:0] K_COLON        = 7'd74;

   // error codes
   localparam logic [1:0] E_NONE    = 2'd0;
   localparam logic [1:0] E_INC     = 2'd1;
   localparam logic [1:0] E_INV     = 2'd2;
   localparam logic [1:0] E_UNKNOWN = 2'd3;

   // lexer modes
   localparam logic [4:0] M_IDLE     = 5'd0;
   localparam logic [4:0] M_COMMENT  = 5'd1;
   localparam logic [4:0] M_DIR_INC  = 5'd2;
   localparam logic [4:0] M_DIR_INV  = 5'd3;
   localparam logic [4:0] M_WS_INC   = 5'd4;
   localparam logic [4:0] M_WS_INV   = 5'd5;
   localparam logic [4:0] M_PATH_INC = 5'd6;
   localparam logic [4:0] M_PATH_INV = 5'd7;
   localparam logic [4:0] M_NUMBER   = 5'd8;
   localparam logic [4:0] M_STRING   = 5'd9;
   localparam logic [4:0] M_IDENT    = 5'd10;
   localparam logic [4:0] M_OP       = 5'd11;
   localparam logic [4:0] M_AMP      = 5'd12;

   typedef struct packed {
      logic [23:0] value_length;
      logic [23:0] value_offset;
      logic [15:0] start_column;
      logic [15:0] start_line;
      logic [1:0]  error_code;
      logic [6:0]  kind;
   } tok_type;

   localparam int TOK_BITS  = $bits(tok_type);
   localparam int DATA_BITS = ((TOK_BITS + 7) / 8) * 8;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // {valid, kind}
   function automatic logic [7:0] op_single(input logic [7:0] c);
      case (c)
         "=": return {1'b1, K_ASSIGN};
         "+": return {1'b1, K_ADD};
         "-": return {1'b1, K_SUB};
         "*": return {1'b1, K_MUL};
         "/": return {1'b1, K_DIV};
         "%": return {1'b1, K_MOD};
         "!": return {1'b1, K_NOT};
         "<": return {1'b1, K_LT};
         ">": return {1'b1, K_GT};
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] op_pair(input logic [7:0] c0, input logic [7:0] c);
      logic [7:0] r;
      r = 8'd0;
      if (c == "=") begin
         case (c0)
            "=": r = {1'b1, K_EQ};
            "+": r = {1'b1, K_PLUS_ASSIGN};
            "-": r = {1'b1, K_MINUS_ASSIGN};
            "*": r = {1'b1, K_MUL_ASSIGN};
            "/": r = {1'b1, K_DIV_ASSIGN};
            "%": r = {1'b1, K_MOD_ASSIGN};
            "!": r = {1'b1, K_NEQ};
            "<": r = {1'b1, K_LTE};
            ">": r = {1'b1, K_GTE};
            default: r = 8'd0;
         endcase
      end else if (c0 == "=" && c == ">") begin
         r = {1'b1, K_ARROW};
      end else if (c0 == "+" && c == "+") begin
         r = {1'b1, K_INC};
      end else if (c0 == "-" && c == "-") begin
         r = {1'b1, K_DEC};
      end else if (c0 == "&" && c == "&") begin
         r = {1'b1, K_AND};
      end else if (c0 == "|" && c == "|") begin
         r = {1'b1, K_OR};
      end
      return r;
   endfunction

   function automatic logic [7:0] punct_kind(input logic [7:0] c);
      case (c)
         "(": return {1'b1, K_LPAREN};
         ")": return {1'b1, K_RPAREN};
         "{": return {1'b1, K_LBRACE};
         "}": return {1'b1, K_RBRACE};
         "[": return {1'b1, K_LBRACK};
         "]": return {1'b1, K_RBRACK};
         ",": return {1'b1, K_COMMA};
         ".": return {1'b1, K_DOT};
         ";": return {1'b1, K_SEMI};
         ":": return {1'b1, K_COLON};
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] dir_char(input logic inv, input logic [3:0] i);
      logic [63:0] s;
      s = inv ? 64'("#involve") : 64'("#include");
      return s[(7 - i[2:0]) * 8 +: 8];
   endfunction

   function automatic logic [7:0] ins_char(input logic [3:0] i);
      logic [47:0] s;
      s = 48'("insert");
      return (i < 4'd6) ? s[(5 - i) * 8 +: 8] : 8'd0;
   endfunction

   function automatic logic [KW_MAX_LEN*8-1:0] kw_text(input int i);
      case (i)
         0:  return 112'("add");
         1:  return 112'("sub");
         2:  return 112'("mul");
         3:  return 112'("div");
         4:  return 112'("mod");
         5:  return 112'("if");
         6:  return 112'("else");
         7:  return 112'("while");
         8:  return 112'("for");
         9:  return 112'("function");
         10: return 112'("void");
         11: return 112'("const");
         12: return 112'("help");
         13: return 112'("end");
         14: return 112'("return");
         15: return 112'("break");
         16: return 112'("continue");
         17: return 112'("true");
         18: return 112'("false");
         19: return 112'("null");
         20: return 112'("system.print");
         21: return 112'("system.input");
         22: return 112'("system.len");
         23: return 112'("system.type");
         24: return 112'("system.output");
         25: return 112'("system.error");
         26: return 112'("system.warning");
         27: return 112'("namespace");
         28: return 112'("enum");
         29: return 112'("class");
         30: return 112'("struct");
         31: return 112'("new");
         32: return 112'("match");
         33: return 112'("case");
         34: return 112'("default");
         35: return 112'("try");
         36: return 112'("catch");
         37: return 112'("finally");
         38: return 112'("in");
         default: return '0;
      endcase
   endfunction

   function automatic int kw_len(input int i);
      logic [KW_MAX_LEN*8-1:0] t;
      int n;
      t = kw_text(i);
      n = 0;
      for (int j = 0; j < KW_MAX_LEN; j++) begin
         if (t[j*8 +: 8] != 8'd0) begin
            n = j + 1;
         end
      end
      return n;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

endpackage

/* design/script_source_tokenizer.sv */
// channel | dir | tdata                  | tuser  | tlast
// req_    | in  | ch                     | at_end | -
// rsp_    | out | kind, error_code, line, | -      | last token of the word
//         |     | column, offset, length |        |
// One source word is taken per cycle while req_tready is high; the lexer state
// updates at the accepting edge. A word yields zero, one or two tokens; they queue
// in a four-entry buffer and leave one per cycle while rsp_tready is high.
// req_tready drops while fewer than two buffer slots are free.
// Synchronous active-high reset returns the lexer to line 1, column 1, offset 0.
module script_source_tokenizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] ch
   input  logic                          req_tuser,  // [0] at_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [6:0] kind, [8:7] error_code, [24:9] start_line, [40:25] start_column,
   // [64:41] value_offset, [88:65] value_length, rest zero
   output logic [sst_pkg::DATA_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import sst_pkg::*;

   localparam int QDEPTH = 4;

   logic [4:0]               mode_ff, mode_in;
   line_type                 line_ff, line_in, tok_line_ff, tok_line_in;
   col_type                  col_ff, col_in, tok_col_ff, tok_col_in;
   off_type                  off_ff, off_in, tok_off_ff, tok_off_in;
   logic [5:0]               ncount_ff, ncount_in;
   logic [3:0]               midx_ff, midx_in;
   logic [7:0]               name_ff [NAME_BUFFER_LEN];
   logic                     name_we;
   logic [NAME_IDX_BITS-1:0] name_wi;
   logic [7:0]               op0_ff, op0_in;

   tok_type                  slot [2];
   logic [1:0]               nemit;
   logic                     refeed;
   logic [6:0]               ident_kind;
   logic                     accept, at_end;
   logic [7:0]               c;

   tok_type                  q_ff [QDEPTH];
   logic                     qlast_ff [QDEPTH];
   logic [1:0]               wr_ff, rd_ff;
   logic [2:0]               cnt_ff;
   logic                     pop;

   function automatic tok_type mk(input logic [6:0] k, input logic [1:0] e,
                                  input line_type l, input col_type cl,
                                  input off_type o, input off_type n);
      tok_type t;
      t.kind         = k;
      t.error_code   = e;
      t.start_line   = l;
      t.start_column = cl;
      t.value_offset = o;
      t.value_length = n;
      return t;
   endfunction

   function automatic off_type body_len(input off_type cur, input off_type tok);
      return (cur > tok) ? cur - tok : '0;
   endfunction

   assign accept = req_tvalid && req_tready;
   assign c      = req_tdata;
   assign at_end = req_tuser || (req_tdata == 8'd0);

   // keyword lookup over the name buffer; lowest table entry wins
   always_comb begin
      logic [KW_MAX_LEN*8-1:0] t;
      int                      n;
      logic                    hit;
      ident_kind = K_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         t   = kw_text(i);
         n   = kw_len(i);
         hit = (int'(ncount_ff) == n);
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (j < n && name_ff[j] != t[(n - 1 - j) * 8 +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            ident_kind = K_KW0 + 7'(i);
         end
      end
   end

   always_comb begin
      logic [7:0] r;
      tok_type    tk;
      mode_in     = mode_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      off_in      = off_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_off_in  = tok_off_ff;
      ncount_in   = ncount_ff;
      midx_in     = midx_ff;
      op0_in      = op0_ff;
      name_we     = 1'b0;
      name_wi     = ncount_ff[NAME_IDX_BITS-1:0];
      slot[0]     = '0;
      slot[1]     = '0;
      nemit       = 2'd0;
      refeed      = 1'b0;
      r           = 8'd0;
      tk          = '0;

      if (at_end) begin
         tk = '0;
         case (mode_ff)
            M_WS_INC:   tk = mk(K_ERROR, E_INC, tok_line_ff, tok_col_ff, tok_off_ff, 24'd8);
            M_WS_INV:   tk = mk(K_ERROR, E_INV, tok_line_ff, tok_col_ff, tok_off_ff, 24'd8);
            M_PATH_INC: tk = mk(K_INCLUDE, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                body_len(off_ff, tok_off_ff));
            M_PATH_INV: tk = mk(K_INVOLVE, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                body_len(off_ff, tok_off_ff));
            M_STRING:   tk = mk(K_STRING, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                body_len(off_ff, tok_off_ff));
            M_NUMBER:   tk = mk(K_NUMBER, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                body_len(off_ff, tok_off_ff));
            M_IDENT:    tk = mk(ident_kind, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                body_len(off_ff, tok_off_ff));
            M_OP: begin
               r = op_single(op0_ff);
               if (r[7]) begin
                  tk = mk(r[6:0], E_NONE, tok_line_ff, tok_col_ff, tok_off_ff, 24'd1);
               end else begin
                  tk = mk(K_ERROR, E_UNKNOWN, tok_line_ff, tok_col_ff, tok_off_ff, '0);
               end
            end
            M_AMP:      tk = mk(K_ERROR, E_UNKNOWN, tok_line_ff, tok_col_ff, tok_off_ff, '0);
            default:    tk = '0;
         endcase
         if (mode_ff >= M_WS_INC && mode_ff <= M_AMP) begin
            slot[nemit[0]] = tk;
            nemit          = nemit + 2'd1;
         end
         slot[nemit[0]] = mk(K_END, E_NONE, line_ff, col_ff, off_ff, '0);
         nemit          = nemit + 2'd1;
         mode_in     = M_IDLE;
         line_in     = line_type'(1);
         col_in      = col_type'(1);
         off_in      = '0;
         tok_line_in = line_type'(1);
         tok_col_in  = col_type'(1);
         tok_off_in  = '0;
         ncount_in   = '0;
         midx_in     = '0;
      end else begin
         case (mode_ff)
            M_IDLE: refeed = 1'b1;
            M_COMMENT: begin
               if (c == 8'h0A) begin
                  mode_in = M_IDLE;
               end
            end
            M_DIR_INC, M_DIR_INV: begin
               mode_in = mode_ff;
               if (mode_ff == M_DIR_INC && midx_ff == 4'd3 && c == "v") begin
                  mode_in = M_DIR_INV;
               end
               if (midx_ff < 4'd8 && dir_char(mode_in == M_DIR_INV, midx_ff) == c) begin
                  midx_in = midx_ff + 4'd1;
                  if (midx_in >= 4'd8) begin
                     mode_in = (mode_in == M_DIR_INC) ? M_WS_INC : M_WS_INV;
                  end
               end else begin
                  mode_in = (c == 8'h0A) ? M_IDLE : M_COMMENT;
               end
            end
            M_WS_INC, M_WS_INV: begin
               if (c == "\"") begin
                  mode_in    = (mode_ff == M_WS_INC) ? M_PATH_INC : M_PATH_INV;
                  tok_off_in = sat_off(off_ff);
               end else if (!is_space(c)) begin
                  slot[nemit[0]] = mk(K_ERROR, (mode_ff == M_WS_INC) ? E_INC : E_INV,
                                      tok_line_ff, tok_col_ff, tok_off_ff, 24'd8);
                  nemit  = nemit + 2'd1;
                  refeed = 1'b1;
               end
            end
            M_PATH_INC, M_PATH_INV, M_STRING: begin
               if (c == "\"") begin
                  slot[nemit[0]] = mk((mode_ff == M_STRING) ? K_STRING :
                                      (mode_ff == M_PATH_INC) ? K_INCLUDE : K_INVOLVE,
                                      E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                      body_len(off_ff, tok_off_ff));
                  nemit   = nemit + 2'd1;
                  mode_in = M_IDLE;
               end
            end
            M_NUMBER: begin
               if (!(is_digit(c) || c == ".")) begin
                  slot[nemit[0]] = mk(K_NUMBER, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                      body_len(off_ff, tok_off_ff));
                  nemit  = nemit + 2'd1;
                  refeed = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == "_" || c == ".") begin
                  name_we = (ncount_ff < 6'(NAME_BUFFER_LEN));
                  if (ncount_ff != 6'd63) begin
                     ncount_in = ncount_ff + 6'd1;
                  end
               end else begin
                  slot[nemit[0]] = mk(ident_kind, E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                      body_len(off_ff, tok_off_ff));
                  nemit  = nemit + 2'd1;
                  refeed = 1'b1;
               end
            end
            M_OP: begin
               r = op_pair(op0_ff, c);
               if (r[7]) begin
                  slot[nemit[0]] = mk(r[6:0], E_NONE, tok_line_ff, tok_col_ff, tok_off_ff,
                                      24'd2);
                  nemit   = nemit + 2'd1;
                  mode_in = M_IDLE;
               end else if (op0_ff == "&" && c == "i") begin
                  mode_in = M_AMP;
                  midx_in = 4'd1;
               end else begin
                  r = op_single(op0_ff);
                  if (r[7]) begin
                     slot[nemit[0]] = mk(r[6:0], E_NONE, tok_line_ff, tok_col_ff,
                                         tok_off_ff, 24'd1);
                  end else begin
                     slot[nemit[0]] = mk(K_ERROR, E_UNKNOWN, tok_line_ff, tok_col_ff,
                                         tok_off_ff, '0);
                  end
                  nemit  = nemit + 2'd1;
                  refeed = 1'b1;
               end
            end
            M_AMP: begin
               if (midx_ff < 4'd6 && ins_char(midx_ff) == c) begin
                  midx_in = midx_ff + 4'd1;
                  if (midx_in >= 4'd6) begin
                     slot[nemit[0]] = mk(K_INSERT, E_NONE, tok_line_ff, tok_col_ff,
                                         tok_off_ff, 24'd7);
                     nemit   = nemit + 2'd1;
                     mode_in = M_IDLE;
                  end
               end else begin
                  slot[nemit[0]] = mk(K_ERROR, E_UNKNOWN, tok_line_ff, tok_col_ff,
                                      tok_off_ff, '0);
                  nemit  = nemit + 2'd1;
                  refeed = 1'b1;
               end
            end
            default: refeed = 1'b1;
         endcase

         // start a token at the current byte
         if (refeed) begin
            mode_in = M_IDLE;
            if (!is_space(c)) begin
               tok_line_in = line_ff;
               tok_col_in  = col_ff;
               tok_off_in  = off_ff;
               if (c == "#") begin
                  mode_in = M_DIR_INC;
                  midx_in = 4'd1;
               end else if (is_digit(c)) begin
                  mode_in = M_NUMBER;
               end else if (c == "\"") begin
                  mode_in    = M_STRING;
                  tok_off_in = sat_off(off_ff);
               end else if (is_alpha(c) || c == "_") begin
                  mode_in   = M_IDENT;
                  name_we   = 1'b1;
                  name_wi   = '0;
                  ncount_in = 6'd1;
               end else if (op_single(c) != 8'd0 || c == "&" || c == "|") begin
                  mode_in = M_OP;
                  op0_in  = c;
               end else begin
                  r = punct_kind(c);
                  if (r[7]) begin
                     slot[nemit[0]] = mk(r[6:0], E_NONE, line_ff, col_ff, off_ff, 24'd1);
                  end else begin
                     slot[nemit[0]] = mk(K_ERROR, E_UNKNOWN, line_ff, col_ff, off_ff, '0);
                  end
                  nemit = nemit + 2'd1;
               end
            end
         end

         if (c == 8'h0A) begin
            line_in = (&line_ff) ? line_ff : line_ff + 1'b1;
            col_in  = col_type'(1);
         end else begin
            col_in = (&col_ff) ? col_ff : col_ff + 1'b1;
         end
         off_in = sat_off(off_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         line_ff     <= line_type'(1);
         col_ff      <= col_type'(1);
         off_ff      <= '0;
         tok_line_ff <= line_type'(1);
         tok_col_ff  <= col_type'(1);
         tok_off_ff  <= '0;
         ncount_ff   <= '0;
         midx_ff     <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         off_ff      <= off_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         tok_off_ff  <= tok_off_in;
         ncount_ff   <= ncount_in;
         midx_ff     <= midx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op0_ff <= op0_in;
         if (name_we) begin
            name_ff[name_wi] <= c;
         end
      end
   end

   // token queue
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff <= 3'(QDEPTH - 2));
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = DATA_BITS'(q_ff[rd_ff]);
   assign rsp_tlast  = qlast_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (accept && nemit != 2'd0) begin
         q_ff[wr_ff]     <= slot[0];
         qlast_ff[wr_ff] <= (nemit == 2'd1);
         if (nemit == 2'd2) begin
            q_ff[wr_ff + 2'd1]     <= slot[1];
            qlast_ff[wr_ff + 2'd1] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (accept) begin
            wr_ff <= wr_ff + nemit;
         end
         if (pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + (accept ? {1'b0, nemit} : 3'd0) - (pop ? 3'd1 : 3'd0);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDEPTH))
      else $error("token queue overflow");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && at_end |=> mode_ff == M_IDLE && line_ff == line_type'(1) && off_ff == '0)
      else $error("lexer state not cleared after end word");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      accept && at_end |=> rsp_tvalid)
      else $error("end word produced no token");

   a_name_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_IDENT |-> ncount_ff != 6'd0)
      else $error("identifier mode with empty name");

endmodule

/* verif/testbench.sv */
module testbench;
   import sst_pkg::*;

   typedef logic [7:0] char_type;

   typedef struct {
      logic [6:0]  kind;
      logic [1:0]  code;
      logic [15:0] line;
      logic [15:0] col;
      logic [23:0] off;
      logic [23:0] len;
      logic        last;
   } token_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'd0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;

   script_source_tokenizer dut (.*);

   always #2 clock = ~clock;

   // lexer copy
   logic [4:0]  lx_mode;
   logic [15:0] lx_line, lx_col, cur_line, cur_col, tk_line, tk_col;
   logic [23:0] lx_off, cur_off, tk_off;
   char_type    name_buf [NAME_BUFFER_LEN];
   logic [5:0]  name_len;
   logic [3:0]  match_pos;

   token_type   word_toks [3];
   int          word_tok_n;
   token_type   due_toks [$];

   int          errors = 0;
   int          cycles = 0;
   int          tx_gap_max = 0;
   int          rx_gap_max = 0;
   int          rx_wait = 0;
   int          rx_hold = 0;

   string keywords [39] = '{"add", "sub", "mul", "div", "mod", "if", "else", "while", "for",
      "function", "void", "const", "help", "end", "return", "break", "continue", "true",
      "false", "null", "system.print", "system.input", "system.len", "system.type",
      "system.output", "system.error", "system.warning", "namespace", "enum", "class",
      "struct", "new", "match", "case", "default", "try", "catch", "finally", "in"};
   string operators [21] = '{"==", "=>", "=", "+=", "++", "-=", "--", "*=", "/=", "%=", "!=",
      "!", "<=", "<", ">=", ">", "&&", "||", "+", "-", "*"};
   string brackets = "(){}[],.;:";
   string word_inc = "#include";
   string word_inv = "#involve";
   string word_ins = "insert";

   function automatic logic blank(char_type c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic digit(char_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter(char_type c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [15:0] sat16(logic [15:0] v);
      return (&v) ? v : v + 16'd1;
   endfunction

   function automatic logic [23:0] sat24(logic [23:0] v);
      return (&v) ? v : v + 24'd1;
   endfunction

   // 1-char operator kind, bit 7 set when valid
   function automatic logic [7:0] single_op(char_type c);
      case (c)
         "=": return {1'b1, K_ASSIGN};
         "+": return {1'b1, K_ADD};
         "-": return {1'b1, K_SUB};
         "*": return {1'b1, K_MUL};
         "/": return {1'b1, K_DIV};
         "%": return {1'b1, K_MOD};
         "!": return {1'b1, K_NOT};
         "<": return {1'b1, K_LT};
         ">": return {1'b1, K_GT};
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] double_op(char_type a, char_type c);
      if (c == "=") begin
         case (a)
            "=": return {1'b1, K_EQ};
            "+": return {1'b1, K_PLUS_ASSIGN};
            "-": return {1'b1, K_MINUS_ASSIGN};
            "*": return {1'b1, K_MUL_ASSIGN};
            "/": return {1'b1, K_DIV_ASSIGN};
            "%": return {1'b1, K_MOD_ASSIGN};
            "!": return {1'b1, K_NEQ};
            "<": return {1'b1, K_LTE};
            ">": return {1'b1, K_GTE};
            default: return 8'd0;
         endcase
      end
      if (a == "=" && c == ">") return {1'b1, K_ARROW};
      if (a == "+" && c == "+") return {1'b1, K_INC};
      if (a == "-" && c == "-") return {1'b1, K_DEC};
      if (a == "&" && c == "&") return {1'b1, K_AND};
      if (a == "|" && c == "|") return {1'b1, K_OR};
      return 8'd0;
   endfunction

   function automatic logic [23:0] span();
      return cur_off > tk_off ? cur_off - tk_off : 24'd0;
   endfunction

   function automatic void add_tok(logic [6:0] k, logic [1:0] e, logic [15:0] l,
                                   logic [15:0] c, logic [23:0] o, logic [23:0] n);
      if (word_tok_n < 3) begin
         word_toks[word_tok_n] = '{k, e, l, c, o, n, 1'b0};
         word_tok_n++;
      end
   endfunction

   function automatic void add_pending(logic [6:0] k, logic [23:0] n);
      add_tok(k, E_NONE, tk_line, tk_col, tk_off, n);
   endfunction

   function automatic void add_fault(logic [1:0] e, logic [23:0] n);
      add_tok(K_ERROR, e, tk_line, tk_col, tk_off, n);
   endfunction

   function automatic void close_name();
      string s;
      logic [6:0] k;
      s = "";
      k = K_IDENT;
      if (name_len <= NAME_BUFFER_LEN) begin
         for (int i = 0; i < name_len; i++) s = {s, string'(name_buf[i])};
         for (int i = 38; i >= 0; i--) if (keywords[i] == s) k = K_KW0 + 7'(i);
      end
      add_pending(k, span());
   endfunction

   function automatic void close_op();
      logic [7:0] r;
      r = single_op(name_buf[0]);
      if (r[7]) add_pending(r[6:0], 24'd1);
      else add_fault(E_UNKNOWN, 24'd0);
   endfunction

   function automatic void start_tok(char_type c);
      lx_mode = M_IDLE;
      if (blank(c)) return;
      tk_line = cur_line;
      tk_col = cur_col;
      tk_off = cur_off;
      if (c == "#") begin
         lx_mode = M_DIR_INC;
         match_pos = 4'd1;
      end else if (digit(c)) begin
         lx_mode = M_NUMBER;
      end else if (c == "\"") begin
         lx_mode = M_STRING;
         tk_off = sat24(cur_off);
      end else if (letter(c) || c == "_") begin
         lx_mode = M_IDENT;
         name_buf[0] = c;
         name_len = 6'd1;
      end else if (single_op(c) != 0 || c == "&" || c == "|") begin
         lx_mode = M_OP;
         name_buf[0] = c;
      end else begin
         for (int i = 0; i < 10; i++) begin
            if (char_type'(brackets[i]) == c) begin
               add_pending(K_LPAREN + 7'(i), 24'd1);
               return;
            end
         end
         add_fault(E_UNKNOWN, 24'd0);
      end
   endfunction

   function automatic void take_char(char_type c);
      logic [7:0] r;
      char_type d;
      case (lx_mode)
         M_COMMENT: if (c == "\n") lx_mode = M_IDLE;
         M_DIR_INC, M_DIR_INV: begin
            if (lx_mode == M_DIR_INC && match_pos == 4'd3 && c == "v") lx_mode = M_DIR_INV;
            d = (lx_mode == M_DIR_INC) ? char_type'(word_inc[match_pos])
                                       : char_type'(word_inv[match_pos]);
            if (match_pos < 4'd8 && d == c) begin
               match_pos++;
               if (match_pos >= 4'd8) lx_mode = (lx_mode == M_DIR_INC) ? M_WS_INC : M_WS_INV;
            end else begin
               lx_mode = (c == "\n") ? M_IDLE : M_COMMENT;
            end
         end
         M_WS_INC, M_WS_INV: begin
            if (c == "\"") begin
               lx_mode = (lx_mode == M_WS_INC) ? M_PATH_INC : M_PATH_INV;
               tk_off = sat24(cur_off);
            end else if (!blank(c)) begin
               add_fault(lx_mode == M_WS_INC ? E_INC : E_INV, 24'd8);
               start_tok(c);
            end
         end
         M_PATH_INC, M_PATH_INV, M_STRING: begin
            if (c == "\"") begin
               add_pending(lx_mode == M_STRING ? K_STRING :
                           lx_mode == M_PATH_INC ? K_INCLUDE : K_INVOLVE, span());
               lx_mode = M_IDLE;
            end
         end
         M_NUMBER: begin
            if (!(digit(c) || c == ".")) begin
               add_pending(K_NUMBER, span());
               start_tok(c);
            end
         end
         M_IDENT: begin
            if (letter(c) || digit(c) || c == "_" || c == ".") begin
               if (name_len < NAME_BUFFER_LEN) name_buf[name_len] = c;
               if (name_len < 6'd63) name_len++;
            end else begin
               close_name();
               start_tok(c);
            end
         end
         M_OP: begin
            r = double_op(name_buf[0], c);
            if (r[7]) begin
               add_pending(r[6:0], 24'd2);
               lx_mode = M_IDLE;
            end else if (name_buf[0] == "&" && c == "i") begin
               lx_mode = M_AMP;
               match_pos = 4'd1;
            end else begin
               close_op();
               start_tok(c);
            end
         end
         M_AMP: begin
            if (match_pos < 4'd6 && char_type'(word_ins[match_pos]) == c) begin
               match_pos++;
               if (match_pos >= 4'd6) begin
                  add_pending(K_INSERT, 24'd7);
                  lx_mode = M_IDLE;
               end
            end else begin
               add_fault(E_UNKNOWN, 24'd0);
               start_tok(c);
            end
         end
         default: start_tok(c);
      endcase
   endfunction

   function automatic void lexer_clear();
      lx_mode = M_IDLE;
      lx_line = 16'd1;
      lx_col = 16'd1;
      lx_off = 24'd0;
      tk_line = 16'd1;
      tk_col = 16'd1;
      tk_off = 24'd0;
      name_len = 6'd0;
      match_pos = 4'd0;
   endfunction

   // advance the lexer by one source word and queue the tokens it yields
   function automatic void lex_word(char_type c, logic at_end);
      word_tok_n = 0;
      cur_line = lx_line;
      cur_col = lx_col;
      cur_off = lx_off;
      if (at_end || c == 8'd0) begin
         case (lx_mode)
            M_WS_INC:   add_fault(E_INC, 24'd8);
            M_WS_INV:   add_fault(E_INV, 24'd8);
            M_PATH_INC: add_pending(K_INCLUDE, span());
            M_PATH_INV: add_pending(K_INVOLVE, span());
            M_STRING:   add_pending(K_STRING, span());
            M_NUMBER:   add_pending(K_NUMBER, span());
            M_IDENT:    close_name();
            M_OP:       close_op();
            M_AMP:      add_fault(E_UNKNOWN, 24'd0);
            default: ;
         endcase
         add_tok(K_END, E_NONE, cur_line, cur_col, cur_off, 24'd0);
         lexer_clear();
      end else begin
         take_char(c);
         if (c == "\n") begin
            lx_line = sat16(lx_line);
            lx_col = 16'd1;
         end else begin
            lx_col = sat16(lx_col);
         end
         lx_off = sat24(lx_off);
      end
      for (int i = 0; i < word_tok_n; i++) begin
         word_toks[i].last = (i == word_tok_n - 1);
         due_toks.push_back(word_toks[i]);
      end
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      errors++;
   endtask

   task automatic send_word(char_type c, logic at_end);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= at_end;
      do @(posedge clock); while (!req_tready);
      lex_word(c, at_end);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_word(char_type'(s[i]), 1'b0);
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // receiver side: stall per token, plus an optional long hold-off
   always begin
      @(negedge clock);
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_toks.size() == 0) begin
            report("unexpected token, kind", rsp_tdata[6:0], -1);
         end else begin
            want = due_toks.pop_front();
            if (rsp_tdata[6:0] != want.kind) report("kind", rsp_tdata[6:0], want.kind);
            if (rsp_tdata[8:7] != want.code) report("error_code", rsp_tdata[8:7], want.code);
            if (rsp_tdata[24:9] != want.line) report("line", rsp_tdata[24:9], want.line);
            if (rsp_tdata[40:25] != want.col) report("column", rsp_tdata[40:25], want.col);
            if (rsp_tdata[64:41] != want.off) report("offset", rsp_tdata[64:41], want.off);
            if (rsp_tdata[88:65] != want.len) report("length", rsp_tdata[88:65], want.len);
            if (rsp_tlast != want.last) report("last", rsp_tlast, want.last);
         end
         rx_wait = $urandom_range(0, rx_gap_max);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 200000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // random source fragment, mostly well-formed
   function automatic string fragment();
      string s;
      int n;
      s = "";
      case ($urandom_range(0, 15))
         0, 1: s = keywords[$urandom_range(0, 38)];
         2: begin
            n = $urandom_range(1, 3) == 3 ? $urandom_range(15, 20) : $urandom_range(1, 5);
            s = "v";
            for (int i = 1; i < n; i++) s = {s, string'(char_type'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25) : "0" + $urandom_range(0, 9)))};
            if ($urandom_range(0, 3) == 0) s = {s, "._x"};
         end
         3: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 9));
         4: s = $urandom_range(0, 1) ? "\"ab c\"" : "\"\"";
         5, 6: s = operators[$urandom_range(0, 20)];
         7: s = string'(char_type'(brackets[$urandom_range(0, 9)]));
         8: s = $urandom_range(0, 1) ? "&insert" : "&ins";
         9: s = $urandom_range(0, 1) ? "#include \"p.s\"" : "#involve\"q\"";
         10: s = $urandom_range(0, 1) ? "#include x" : "#involve\n";
         11: s = "# note\n#inc\n";
         12: s = $urandom_range(0, 1) ? "\n" : "\t ";
         13: s = $urandom_range(0, 1) ? "|a" : "&&%";
         default: s = string'(char_type'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 2) != 0) s = {s, " "};
      return s;
   endfunction

   task automatic send_random(int count);
      string s;
      int sent;
      sent = 0;
      while (sent < count) begin
         s = fragment();
         send_text(s);
         sent += s.len();
         if ($urandom_range(0, 9) == 0) begin
            send_word(char_type'($urandom_range(0, 255)), 1'b1);
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      tx_gap_max = 0;
      rx_gap_max = 0;
      send_text("#include x&in|");
      send_word(8'hFF, 1'b0);
      send_text("\"s");
      send_word(8'd0, 1'b0);
      send_text("#involve \"");
      send_word(8'hAA, 1'b1);
   endtask

   task automatic test_random_idle();
      tx_gap_max = 16;
      rx_gap_max = 16;
      send_random(80);
      tx_gap_max = 0;
      rx_gap_max = 0;
      send_random(40);
      send_word(8'd0, 1'b1);
   endtask

   task automatic test_backpressure();
      tx_gap_max = 0;
      rx_gap_max = 0;
      rx_hold = 300;
      send_text("a+=b;x==y ++z (1) [2],");
      go_quiet();
      wait (due_toks.size() == 0);
      send_text("c -- d");
      send_word(8'd0, 1'b1);
   endtask

   task automatic test_random_tail();
      tx_gap_max = 4;
      rx_gap_max = 8;
      send_random(35);
      send_word(8'd0, 1'b1);
   endtask

   initial begin
      lexer_clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_idle();
      test_backpressure();
      test_random_tail();
      go_quiet();
      wait (due_toks.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
